// File: rtl/core/timestamp_interval_statistics_assert.svh
`ifndef TIMESTAMP_INTERVAL_STATISTICS_ASSERT_SVH
`define TIMESTAMP_INTERVAL_STATISTICS_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define TIS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define TIS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/tis_pkg.sv
package tis_pkg;

   localparam int DEF_POINT_COUNT = 8;
   localparam int DEF_LIST_DEPTH  = 256;

   localparam int ACT_W   = 2;
   localparam int PIDX_W  = 3;
   localparam int TS_W    = 32;
   localparam int SCNT_W  = 9;
   localparam int STAT_W  = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 112;

   typedef enum logic [ACT_W-1:0] {
      ACT_MARK  = 2'd0,
      ACT_QUERY = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_MISMATCH = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSEL_PT = 2'd0,
      CSEL_SP = 2'd1,
      CSEL_EP = 2'd2
   } cnt_sel_type;

   typedef enum logic [1:0] {
      SSEL_START = 2'd0,
      SSEL_END   = 2'd1,
      SSEL_NEXT  = 2'd2
   } st_sel_type;

   typedef struct packed {
      logic        capture;
      logic        clear;
      cnt_sel_type cnt_sel;
      logic        mark_wr;
      logic        lat_ns;
      logic        q_init;
      st_sel_type  st_sel;
      logic        lat_a;
      logic        accum;
      logic        div_step;
      logic        load_out;
   } cmd_type;

   typedef struct packed {
      logic mark_ok;
      logic chk_ok;
      logic last_pair;
      logic out_busy;
   } sts_type;

endpackage

// File: rtl/core/tis_ram.sv
module tis_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/tis_dpath.sv
module tis_dpath import tis_pkg::*; #(
   parameter int POINT_COUNT = DEF_POINT_COUNT,
   parameter int LIST_DEPTH  = DEF_LIST_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output sts_type           sts,
   input  logic [PIDX_W-1:0] req_point_index,
   input  logic [TS_W-1:0]   req_timestamp,
   input  logic [PIDX_W-1:0] req_start_point,
   input  logic [PIDX_W-1:0] req_end_point,
   input  logic              rsp_tready,
   output logic              rsp_valid,
   output logic [TS_W-1:0]   rsp_min_ticks,
   output logic [TS_W-1:0]   rsp_mean_ticks,
   output logic [TS_W-1:0]   rsp_max_ticks,
   output logic [SCNT_W-1:0] rsp_sample_count,
   output status_type        rsp_status
);

   `include "timestamp_interval_statistics_assert.svh"

   localparam int PW = $clog2(POINT_COUNT);
   localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CW = $clog2(LIST_DEPTH + 1);
   localparam int SW = TS_W + CW;
   localparam int SD = POINT_COUNT * (2 ** IW);

   function automatic logic [PW-1:0] paddr(input logic [PIDX_W-1:0] p);
      logic [6:0] w;
      w = 7'(p);
      return w[PW-1:0];
   endfunction

   function automatic logic in_range(input logic [PIDX_W-1:0] p);
      return 7'(p) < 7'(POINT_COUNT);
   endfunction

   logic [PIDX_W-1:0] pt_ff, sp_ff, ep_ff;
   logic [TS_W-1:0]   ts_ff;
   logic [CW-1:0]     ns_ff, ne_ff, idx_ff;
   status_type        stat_ff;
   logic [TS_W-1:0]   a_ff, lo_ff, hi_ff;
   logic [SW-1:0]     sum_ff;
   logic [CW:0]       rem_ff;
   logic [POINT_COUNT-1:0] valid_ff;
   logic [PW-1:0]     cnt_ra_ff;
   logic              cnt_rng_ff;

   logic              rsp_valid_ff;
   logic [TS_W-1:0]   min_ff, mean_ff, max_ff;
   logic [SCNT_W-1:0] scnt_ff;
   status_type        rstat_ff;

   logic [PIDX_W-1:0] cnt_pidx;
   logic [PW-1:0]     cnt_raddr;
   logic [CW-1:0]     cnt_rdata, cnt_val, idx_nx;
   logic [PW+IW-1:0]  st_raddr, st_waddr;
   logic [TS_W-1:0]   st_rdata, diff;
   logic [CW:0]       rem_sh;
   logic              rem_ge;
   logic [31:0]       ne_wide;

   always_comb begin
      case (cmd.cnt_sel)
         CSEL_PT: cnt_pidx = pt_ff;
         CSEL_SP: cnt_pidx = sp_ff;
         CSEL_EP: cnt_pidx = ep_ff;
         default: cnt_pidx = pt_ff;
      endcase
   end

   assign cnt_raddr = paddr(cnt_pidx);
   assign cnt_val   = (cnt_rng_ff && valid_ff[cnt_ra_ff]) ? cnt_rdata : '0;
   assign idx_nx    = idx_ff + 1'b1;
   assign st_waddr  = {paddr(pt_ff), cnt_val[IW-1:0]};

   always_comb begin
      case (cmd.st_sel)
         SSEL_START: st_raddr = {paddr(sp_ff), idx_ff[IW-1:0]};
         SSEL_END:   st_raddr = {paddr(ep_ff), idx_ff[IW-1:0]};
         SSEL_NEXT:  st_raddr = {paddr(sp_ff), idx_nx[IW-1:0]};
         default:    st_raddr = {paddr(sp_ff), idx_ff[IW-1:0]};
      endcase
   end

   tis_ram #(
      .WIDTH (CW),
      .DEPTH (POINT_COUNT)
   ) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cmd.mark_wr),
      .wr_addr (paddr(pt_ff)),
      .wr_data (cnt_val + 1'b1),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   tis_ram #(
      .WIDTH (TS_W),
      .DEPTH (SD)
   ) u_store_ram (
      .clock   (clock),
      .wr_en   (cmd.mark_wr),
      .wr_addr (st_waddr),
      .wr_data (ts_ff),
      .rd_addr (st_raddr),
      .rd_data (st_rdata)
   );

   assign diff   = st_rdata - a_ff;
   assign rem_sh = {rem_ff[CW-1:0], sum_ff[SW-1]};
   assign rem_ge = rem_sh >= {1'b0, ne_ff};
   assign ne_wide = 32'(ne_ff);

   always_ff @(posedge clock) begin
      cnt_ra_ff  <= cnt_raddr;
      cnt_rng_ff <= in_range(cnt_pidx);
      if (cmd.capture) begin
         pt_ff <= req_point_index;
         ts_ff <= req_timestamp;
         sp_ff <= req_start_point;
         ep_ff <= req_end_point;
      end
      if (cmd.lat_ns) begin
         ns_ff <= cnt_val;
      end
      if (cmd.q_init) begin
         ne_ff  <= cnt_val;
         idx_ff <= '0;
         sum_ff <= '0;
         rem_ff <= '0;
         lo_ff  <= '1;
         hi_ff  <= '0;
         if (ns_ff != cnt_val) begin
            stat_ff <= ST_MISMATCH;
         end else if (cnt_val == '0) begin
            stat_ff <= ST_EMPTY;
         end else begin
            stat_ff <= ST_OK;
         end
      end
      if (cmd.lat_a) begin
         a_ff <= st_rdata;
      end
      if (cmd.accum) begin
         sum_ff <= sum_ff + SW'(diff);
         idx_ff <= idx_nx;
         if (diff < lo_ff) begin
            lo_ff <= diff;
         end
         if (diff > hi_ff) begin
            hi_ff <= diff;
         end
      end
      if (cmd.div_step) begin
         rem_ff <= rem_ge ? (rem_sh - {1'b0, ne_ff}) : rem_sh;
         sum_ff <= {sum_ff[SW-2:0], rem_ge};
      end
      if (cmd.load_out) begin
         rstat_ff <= stat_ff;
         if (stat_ff == ST_OK) begin
            min_ff  <= lo_ff;
            mean_ff <= sum_ff[TS_W-1:0];
            max_ff  <= hi_ff;
            scnt_ff <= ne_wide[SCNT_W-1:0];
         end else begin
            min_ff  <= '0;
            mean_ff <= '0;
            max_ff  <= '0;
            scnt_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            valid_ff <= '0;
         end else if (cmd.mark_wr) begin
            valid_ff[paddr(pt_ff)] <= 1'b1;
         end
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.mark_ok   = cnt_rng_ff && (cnt_val < CW'(LIST_DEPTH));
   assign sts.chk_ok    = (ns_ff == cnt_val) && (cnt_val != '0);
   assign sts.last_pair = idx_nx == ne_ff;
   assign sts.out_busy  = rsp_valid_ff && !rsp_tready;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_ticks    = min_ff;
   assign rsp_mean_ticks   = mean_ff;
   assign rsp_max_ticks    = max_ff;
   assign rsp_sample_count = scnt_ff;
   assign rsp_status       = rstat_ff;

   `TIS_ASSERT_NOW(a_idx_below_count, cmd.accum, idx_ff < ne_ff,
      "pair index ran past list length")
   `TIS_ASSERT_NOW(a_mean_in_range, cmd.load_out && (stat_ff == ST_OK),
      (sum_ff[TS_W-1:0] >= lo_ff) && (sum_ff[TS_W-1:0] <= hi_ff),
      "mean outside min and max")

endmodule

// File: rtl/core/tis_ctrl.sv
module tis_ctrl import tis_pkg::*; #(
   parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [ACT_W-1:0] req_action,
   input  sts_type          sts,
   output cmd_type          cmd
);

   `include "timestamp_interval_statistics_assert.svh"

   localparam int CW  = $clog2(LIST_DEPTH + 1);
   localparam int SW  = TS_W + CW;
   localparam int DCW = $clog2(SW);

   typedef enum logic [10:0] {
      S_IDLE = 11'b000_0000_0001,
      S_MRD  = 11'b000_0000_0010,
      S_MWR  = 11'b000_0000_0100,
      S_QRS  = 11'b000_0000_1000,
      S_QRE  = 11'b000_0001_0000,
      S_QCHK = 11'b000_0010_0000,
      S_QRDA = 11'b000_0100_0000,
      S_QRDB = 11'b000_1000_0000,
      S_QACC = 11'b001_0000_0000,
      S_DIV  = 11'b010_0000_0000,
      S_OUT  = 11'b100_0000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic [DCW-1:0] dc_ff, dc_in;
   logic           accept;

   assign req_tready = state_ff == S_IDLE;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      dc_in        = dc_ff;
      cmd          = '0;
      cmd.cnt_sel  = CSEL_PT;
      cmd.st_sel   = SSEL_START;
      case (state_ff)
         S_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               case (req_action)
                  ACT_MARK:  state_in = S_MRD;
                  ACT_QUERY: state_in = S_QRS;
                  ACT_CLEAR: cmd.clear = 1'b1;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_MRD: begin
            cmd.cnt_sel = CSEL_PT;
            state_in    = S_MWR;
         end
         S_MWR: begin
            cmd.mark_wr = sts.mark_ok;
            state_in    = S_IDLE;
         end
         S_QRS: begin
            cmd.cnt_sel = CSEL_SP;
            state_in    = S_QRE;
         end
         S_QRE: begin
            cmd.lat_ns  = 1'b1;
            cmd.cnt_sel = CSEL_EP;
            state_in    = S_QCHK;
         end
         S_QCHK: begin
            cmd.q_init = 1'b1;
            state_in   = sts.chk_ok ? S_QRDA : S_OUT;
         end
         S_QRDA: begin
            cmd.st_sel = SSEL_START;
            state_in   = S_QRDB;
         end
         S_QRDB: begin
            cmd.lat_a  = 1'b1;
            cmd.st_sel = SSEL_END;
            state_in   = S_QACC;
         end
         S_QACC: begin
            cmd.accum  = 1'b1;
            cmd.st_sel = SSEL_NEXT;
            if (sts.last_pair) begin
               dc_in    = DCW'(SW - 1);
               state_in = S_DIV;
            end else begin
               state_in = S_QRDB;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            dc_in        = dc_ff - 1'b1;
            if (dc_ff == '0) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!sts.out_busy) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         dc_ff    <= dc_in;
      end
   end

   `TIS_ASSERT_NOW(a_no_result_overwrite, cmd.load_out, !sts.out_busy,
      "result loaded while previous one still held")
   `TIS_ASSERT_NEXT(a_div_then_out, (state_ff == S_DIV) && (dc_ff == '0),
      state_ff == S_OUT, "divider did not finish into output state")
   `TIS_ASSERT_NEXT(a_query_starts, accept && (req_action == ACT_QUERY),
      state_ff == S_QRS, "query accepted but count read not started")

endmodule

// File: rtl/core/timestamp_interval_statistics.sv
// channel   | ports            | tdata (lsb up)                         | tuser
// ----------+------------------+----------------------------------------+--------
// request   | req_t*  (slave)  | point_index, timestamp, start, end     | action
// response  | rsp_t*  (master) | min, mean, max, sample_count           | status
//
// mark: reads the list count, then writes; clear: acts when accepted; query: for n
// stored pairs, two memory reads per pair, then one quotient bit per cycle
// query with empty or mismatched lists goes straight to the output state
// reset clears the list counts at once, the capture memory needs no clearing
// a finished query waits in its output state while the previous result is unread
module timestamp_interval_statistics import tis_pkg::*; #(
   parameter int POINT_COUNT = DEF_POINT_COUNT,
   parameter int LIST_DEPTH  = DEF_LIST_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // point_index[2:0], timestamp[34:3], start_point[37:35], end_point[40:38]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action[1:0]
   input  logic [ACT_W-1:0]      req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // min_ticks[31:0], mean_ticks[63:32], max_ticks[95:64], sample_count[104:96]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // status[1:0]
   output logic [STAT_W-1:0]     rsp_tuser
);

   cmd_type           cmd;
   sts_type           sts;
   logic [TS_W-1:0]   min_ticks, mean_ticks, max_ticks;
   logic [SCNT_W-1:0] sample_count;
   status_type        status;

   tis_ctrl #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   tis_dpath #(
      .POINT_COUNT (POINT_COUNT),
      .LIST_DEPTH  (LIST_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_point_index  (req_tdata[2:0]),
      .req_timestamp    (req_tdata[34:3]),
      .req_start_point  (req_tdata[37:35]),
      .req_end_point    (req_tdata[40:38]),
      .rsp_tready       (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_min_ticks    (min_ticks),
      .rsp_mean_ticks   (mean_ticks),
      .rsp_max_ticks    (max_ticks),
      .rsp_sample_count (sample_count),
      .rsp_status       (status)
   );

   assign rsp_tdata = {7'b0, sample_count, max_ticks, mean_ticks, min_ticks};
   assign rsp_tuser = status;

endmodule
